[hw/rtl/tfq_pkg.sv]
// tfq_pkg: shared types, constants and config record for the thermocouple frame qualifier
// no dependencies; imported by tfq_decide, thermocouple_frame_qualifier_core and tb
package tfq_pkg;

	localparam int unsigned FrameW = 16;
	localparam int unsigned TempW  = 12;

	// frame is usable when bit 15 and bits 1..0 are all clear
	localparam logic [FrameW-1:0] ValidMask = 16'h8003;
	// open thermocouple flag, d2
	localparam logic [FrameW-1:0] FaultBit  = 16'h0004;
	localparam logic [TempW-1:0]  TempMask  = 12'hFFF;
	localparam int unsigned       TempShift = 3;

	// register reset values
	localparam logic       AseReset     = 1'b0;
	localparam logic [2:0] AttemptReset = 3'd4;
	localparam logic [1:0] FilterReset  = 2'd3;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_ANTI_SHIFT   = 2'd0,
		REG_MAX_ATTEMPTS = 2'd1,
		REG_FILTER       = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_OPEN    = 2'd2
	} status_t;

	typedef enum logic {
		PH_WAIT   = 1'b0,
		PH_FILTER = 1'b1
	} phase_t;

	typedef struct packed {
		logic       anti_shift_enable;
		logic [2:0] max_attempts;
		logic [1:0] filter_frames;
	} tfq_cfg_t;

	typedef struct packed {
		phase_t            phase;
		logic [2:0]        attempts;
		logic [1:0]        fcount;
		logic [FrameW-1:0] best;
	} tfq_state_t;

	typedef struct packed {
		logic              fire;
		status_t           status;
		logic [TempW-1:0]  temp;
		logic [FrameW-1:0] frame;
	} tfq_result_t;

endpackage

[hw/rtl/tfq_decide.sv]
// tfq_decide: per-frame qualification step, next state and result for one frame
// depends on tfq_pkg
module tfq_decide import tfq_pkg::*; (
	input  tfq_cfg_t          cfg,
	input  tfq_state_t        cur,
	input  logic [FrameW-1:0] frame,
	output tfq_state_t        nxt,
	output tfq_result_t       res
);

	logic              ok;
	logic [2:0]        tries;
	logic [1:0]        window;
	logic [2:0]        att_inc;
	logic [1:0]        fc_inc;
	logic [FrameW-1:0] best_upd;
	logic              emit_now;
	logic [FrameW-1:0] emit_frame;
	logic              give_up;
	logic              win_done;
	logic              open_win;

	assign ok       = (frame & ValidMask) == '0;
	assign tries    = (cfg.max_attempts == 3'd0) ? 3'd1 : cfg.max_attempts;
	assign window   = (cfg.filter_frames == 2'd0) ? 2'd1 : cfg.filter_frames;
	assign att_inc  = cur.attempts + 3'd1;
	assign fc_inc   = cur.fcount + 2'd1;
	assign best_upd = (ok && frame < cur.best) ? frame : cur.best;
	assign give_up  = att_inc >= tries;
	assign win_done = fc_inc >= window;
	assign open_win = cfg.anti_shift_enable && (window > 2'd1);

	// next state
	always_comb begin
		nxt = cur;
		case (cur.phase)
			PH_FILTER: begin
				nxt.best   = best_upd;
				nxt.fcount = fc_inc;
				if (win_done) begin
					nxt.phase  = PH_WAIT;
					nxt.fcount = 2'd0;
				end
			end
			PH_WAIT: begin
				if (!ok) begin
					nxt.attempts = give_up ? 3'd0 : att_inc;
				end else begin
					nxt.attempts = 3'd0;
					if (open_win) begin
						nxt.best   = frame;
						nxt.fcount = 2'd1;
						nxt.phase  = PH_FILTER;
					end
				end
			end
			default: nxt = cur;
		endcase
	end

	// result
	always_comb begin
		emit_now   = 1'b0;
		emit_frame = frame;
		res        = '0;
		res.status = ST_OK;
		case (cur.phase)
			PH_FILTER: begin
				emit_now   = win_done;
				emit_frame = best_upd;
			end
			PH_WAIT: begin
				if (!ok) begin
					res.fire   = give_up;
					res.status = ST_INVALID;
					res.frame  = frame;
				end else begin
					emit_now = !open_win;
				end
			end
			default: emit_now = 1'b0;
		endcase
		if (emit_now) begin
			res.fire  = 1'b1;
			res.frame = emit_frame;
			if ((emit_frame & FaultBit) != '0) begin
				res.status = ST_OPEN;
			end else begin
				res.status = ST_OK;
				res.temp   = emit_frame[TempShift +: TempW] & TempMask;
			end
		end
	end

endmodule

[hw/rtl/thermocouple_frame_qualifier_core.sv]
// thermocouple_frame_qualifier_core: top level, input register, qualifier state and result register
// depends on tfq_pkg and tfq_decide
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-------------------------------------------
//  in       | in        | in_valid / in_stall | frame[15:0]
//  out      | out       | out_valid/out_stall | status[1:0], temperature_quarter_c[11:0],
//           |           |                     | chosen_frame[15:0]
//  cfg      | in        | cfg_we              | cfg_index[1:0], cfg_data[2:0]
//
// one frame per cycle sustained while the output is not stalled; a frame lands in the input register,
// and the qualifier step plus result register write happen when it moves on, so a result beat is
// offered from the result register once its frame has left the input register
// the step is a single pass of compare and select logic, no iteration
// arst_n clears the qualifier state and the valid flags and sets the config registers to their reset values
// out_stall holds the result register; the input register then holds its frame and
// in_stall rises only while it is full and cannot move on
module thermocouple_frame_qualifier_core import tfq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [FrameW-1:0] frame,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [TempW-1:0]  temperature_quarter_c,
	output logic [FrameW-1:0] chosen_frame,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [2:0]        cfg_data
);

	tfq_cfg_t          cfg_q;
	tfq_state_t        state_q;
	tfq_state_t        state_nxt;
	tfq_result_t       res;

	logic              valid_s1;
	logic [FrameW-1:0] frame_s1;
	logic              out_valid_q;
	status_t           status_q;
	logic [TempW-1:0]  temp_q;
	logic [FrameW-1:0] chosen_q;
	logic              adv;
	logic              in_take;

	// the input register moves on when the result register is empty or being drained
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_take  = in_valid && !in_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.anti_shift_enable <= AseReset;
			cfg_q.max_attempts      <= AttemptReset;
			cfg_q.filter_frames     <= FilterReset;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ANTI_SHIFT:   cfg_q.anti_shift_enable <= cfg_data[0];
				REG_MAX_ATTEMPTS: cfg_q.max_attempts      <= cfg_data;
				REG_FILTER:       cfg_q.filter_frames     <= cfg_data[1:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			frame_s1 <= frame;
		end
	end

	tfq_decide u_decide (
		.cfg   (cfg_q),
		.cur   (state_q),
		.frame (frame_s1),
		.nxt   (state_nxt),
		.res   (res)
	);

	// qualifier state, updated once per frame as it leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase    <= PH_WAIT;
			state_q.attempts <= 3'd0;
			state_q.fcount   <= 2'd0;
			state_q.best     <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// result register; a frame that gives no result leaves it free for draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res.fire;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.fire) begin
			status_q <= res.status;
			temp_q   <= res.temp;
			chosen_q <= res.frame;
		end
	end

	assign out_valid             = out_valid_q;
	assign status                = status_q;
	assign temperature_quarter_c = temp_q;
	assign chosen_frame          = chosen_q;

`ifndef SYNTHESIS
	// faults and give-ups carry no temperature
	a_temp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_OK |-> temp_q == '0)
		else $error("temperature set on non-ok result");

	// window counter is live only while filtering
	a_fcount_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_FILTER) == (state_q.fcount != 2'd0))
		else $error("filter count out of step with phase");

	// a new result beat only comes from a frame leaving the input register
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv))
		else $error("result beat without a frame");

	// no back-pressure on the input while the input register is empty
	a_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled with empty input register");
`endif

endmodule

[tb/tb.sv]
// tb: self-checking bench for thermocouple_frame_qualifier_core, driver and monitor on clocked blocks
// depends on tfq_pkg and the core; predicts every reading from its own copy of the qualifier state
module tb;
	import tfq_pkg::*;

	localparam int unsigned RunLimit  = 500000;
	localparam int unsigned TailWait  = 10;
	localparam int unsigned SettleLen = 6;
	localparam int unsigned HoldLen   = 150;

	typedef enum {SEND_FRAME, WRITE_REG, WAIT_IDLE} op_kind_t;

	typedef struct {
		op_kind_t          kind;
		logic [FrameW-1:0] value;
		reg_idx_t          idx;
		logic [2:0]        data;
		int unsigned       gap;
	} line_op_t;

	typedef struct {
		status_t           status;
		logic [TempW-1:0]  temp;
		logic [FrameW-1:0] frame;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [FrameW-1:0] frame = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [1:0]        status;
	logic [TempW-1:0]  temperature_quarter_c;
	logic [FrameW-1:0] chosen_frame;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_index = '0;
	logic [2:0]        cfg_data = '0;

	thermocouple_frame_qualifier_core dut (
		.clk                   (clk),
		.arst_n                (arst_n),
		.in_valid              (in_valid),
		.in_stall              (in_stall),
		.frame                 (frame),
		.out_valid             (out_valid),
		.out_stall             (out_stall),
		.status                (status),
		.temperature_quarter_c (temperature_quarter_c),
		.chosen_frame          (chosen_frame),
		.cfg_we                (cfg_we),
		.cfg_index             (cfg_index),
		.cfg_data              (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	line_op_t frame_script[$];
	reading_t pending_readings[$];

	// register copy, follows every write as it is issued
	logic       ase_on        = AseReset;
	logic [2:0] attempt_limit = AttemptReset;
	logic [1:0] window_len    = FilterReset;

	// qualifier state copy
	phase_t            win_phase = PH_WAIT;
	logic [2:0]        bad_run   = '0;
	logic [1:0]        win_fill  = '0;
	logic [FrameW-1:0] win_best  = '0;

	int unsigned readings_due  = 0;
	int unsigned readings_seen = 0;
	int unsigned frames_taken  = 0;
	int unsigned faults        = 0;
	int unsigned cycles        = 0;
	int unsigned hold_left     = 0;
	int unsigned hold_at       = 300;
	logic        back_to_back  = 1'b0;

	// ok or open thermocouple reading from a chosen valid frame
	function automatic void report_frame(input logic [FrameW-1:0] f);
		reading_t r;
		if ((f & FaultBit) != '0) begin
			r.status = ST_OPEN;
			r.temp   = '0;
		end else begin
			r.status = ST_OK;
			r.temp   = f[TempShift +: TempW];
		end
		r.frame = f;
		pending_readings.push_back(r);
		readings_due++;
	endfunction

	function automatic void qualify_frame(input logic [FrameW-1:0] f);
		logic [2:0] tries;
		logic [1:0] span;
		reading_t   r;
		tries = (attempt_limit == 3'd0) ? 3'd1 : attempt_limit;
		span  = (window_len == 2'd0) ? 2'd1 : window_len;
		if (win_phase == PH_FILTER) begin
			// invalid frames still use up a slot of the window
			if ((f & ValidMask) == '0 && f < win_best)
				win_best = f;
			win_fill = win_fill + 2'd1;
			if (win_fill >= span) begin
				report_frame(win_best);
				win_phase = PH_WAIT;
				win_fill  = '0;
			end
		end else if ((f & ValidMask) != '0) begin
			bad_run = bad_run + 3'd1;
			if (bad_run >= tries) begin
				bad_run  = '0;
				r.status = ST_INVALID;
				r.temp   = '0;
				r.frame  = f;
				pending_readings.push_back(r);
				readings_due++;
			end
		end else begin
			bad_run = '0;
			if (ase_on && span > 2'd1) begin
				win_best  = f;
				win_fill  = 2'd1;
				win_phase = PH_FILTER;
			end else begin
				report_frame(f);
			end
		end
	endfunction

	task automatic add_frame(input logic [FrameW-1:0] f);
		line_op_t op;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		op.kind  = SEND_FRAME;
		op.value = f;
		op.idx   = REG_ANTI_SHIFT;
		op.data  = '0;
		if (back_to_back || pick < 55)
			op.gap = 0;
		else if (pick < 90)
			op.gap = $urandom_range(1, 3);
		else
			op.gap = $urandom_range(8, 40);
		frame_script.push_back(op);
	endtask

	task automatic add_write(input reg_idx_t idx, input logic [2:0] data);
		line_op_t op;
		op.kind  = WRITE_REG;
		op.value = '0;
		op.idx   = idx;
		op.data  = data;
		op.gap   = 0;
		frame_script.push_back(op);
	endtask

	task automatic add_settle();
		line_op_t op;
		op.kind  = WAIT_IDLE;
		op.value = '0;
		op.idx   = REG_ANTI_SHIFT;
		op.data  = '0;
		op.gap   = 0;
		frame_script.push_back(op);
	endtask

	// sender: one op per cycle at most, frames held until taken
	always @(posedge clk or negedge arst_n) begin : drive
		logic              nx_valid;
		logic [FrameW-1:0] nx_frame;
		logic              nx_we;
		logic [1:0]        nx_idx;
		logic [2:0]        nx_data;
		int unsigned       gap_left;
		int unsigned       quiet;
		line_op_t          op;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			frame     <= '0;
			cfg_we    <= 1'b0;
			cfg_index <= '0;
			cfg_data  <= '0;
			gap_left  = 0;
			quiet     = 0;
		end else begin
			nx_valid = in_valid;
			nx_frame = frame;
			nx_we    = 1'b0;
			nx_idx   = cfg_index;
			nx_data  = cfg_data;
			if (in_valid && !in_stall) begin
				qualify_frame(frame);
				frames_taken <= frames_taken + 1;
				nx_valid = 1'b0;
			end
			// idle once no frame is offered and every due reading is back
			if (!in_valid && readings_seen == readings_due)
				quiet++;
			else
				quiet = 0;
			if (!nx_valid) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (frame_script.size() != 0) begin
					op = frame_script[0];
					case (op.kind)
						SEND_FRAME: begin
							nx_valid = 1'b1;
							nx_frame = op.value;
							gap_left = op.gap;
							void'(frame_script.pop_front());
						end
						WRITE_REG: begin
							nx_we   = 1'b1;
							nx_idx  = op.idx;
							nx_data = op.data;
							case (op.idx)
								REG_ANTI_SHIFT:   ase_on = op.data[0];
								REG_MAX_ATTEMPTS: attempt_limit = op.data;
								REG_FILTER:       window_len = op.data[1:0];
								default: ;
							endcase
							void'(frame_script.pop_front());
						end
						default: begin
							if (quiet >= SettleLen)
								void'(frame_script.pop_front());
						end
					endcase
				end
			end
			in_valid  <= nx_valid;
			frame     <= nx_frame;
			cfg_we    <= nx_we;
			cfg_index <= nx_idx;
			cfg_data  <= nx_data;
		end
	end

	// long receiver hold-off so the core backs up and stalls its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_left == 0 && frames_taken >= hold_at) begin
			hold_left <= HoldLen;
			hold_at   <= hold_at + 400;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// receiver: checks each reading beat, then picks its stall pattern
	always @(posedge clk or negedge arst_n) begin : watch
		reading_t    want;
		logic        rx_busy;
		int unsigned rx_left;
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_busy   = 1'b0;
			rx_left   = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_readings.size() == 0) begin
					faults++;
					if (faults <= 10)
						$display("unexpected reading at %0t: status %0d temp %0d frame %h",
							$time, status, temperature_quarter_c, chosen_frame);
				end else begin
					want = pending_readings.pop_front();
					readings_seen <= readings_seen + 1;
					if (status != want.status || temperature_quarter_c != want.temp ||
							chosen_frame != want.frame) begin
						faults++;
						if (faults <= 10)
							$display("mismatch at %0t: status %0d/%0d temp %0d/%0d frame %h/%h (exp/got)",
								$time, want.status, status, want.temp, temperature_quarter_c,
								want.frame, chosen_frame);
					end
				end
			end
			if (rx_left == 0) begin
				rx_busy = ($urandom_range(0, 99) < 35);
				if (rx_busy)
					rx_left = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 3) : $urandom_range(10, 60);
				else
					rx_left = ($urandom_range(0, 6) != 0) ? $urandom_range(1, 8) : $urandom_range(50, 200);
			end else begin
				rx_left--;
			end
			out_stall <= rx_busy || (hold_left != 0);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == RunLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned total;
		int unsigned len;
		int unsigned valid_pct;
		int unsigned k;
		logic [FrameW-1:0] f;
		logic [FrameW-1:0] m;

		// directed: extremes, open thermocouple, retries, filter window corners
		add_frame(16'h0000);
		add_frame(16'h7FF8);
		add_frame(16'h7FFC);
		add_frame(16'h0004);
		add_frame(16'h8000);
		add_frame(16'h0001);
		add_frame(16'h0002);
		add_frame(16'hFFFF);
		add_settle();
		add_write(REG_MAX_ATTEMPTS, 3'd0);
		add_frame(16'h8003);
		add_settle();
		add_write(REG_MAX_ATTEMPTS, 3'd7);
		for (k = 0; k < 6; k++)
			add_frame(16'h8000 | 16'(k));
		add_frame(16'h0008);
		add_settle();
		add_write(REG_MAX_ATTEMPTS, 3'd1);
		add_write(REG_ANTI_SHIFT, 3'd1);
		// invalid frame inside the window is skipped for the minimum
		add_frame(16'h1238);
		add_frame(16'h8001);
		add_frame(16'h1230);
		add_settle();
		add_write(REG_FILTER, 3'd0);
		add_frame(16'h0F00);
		add_settle();
		add_write(REG_FILTER, 3'd1);
		add_frame(16'h0010);
		add_settle();
		add_write(REG_FILTER, 3'd2);
		add_frame(16'h4004);
		add_frame(16'h3FF8);
		add_settle();
		add_write(REG_FILTER, 3'd3);
		add_frame(16'h2004);
		// registers change mid window, window keeps running
		add_settle();
		add_write(REG_ANTI_SHIFT, 3'd0);
		add_write(REG_FILTER, 3'd2);
		add_frame(16'h3000);

		// random blocks, each under its own register setting
		total = 0;
		while (total < 925) begin
			add_settle();
			if ($urandom_range(0, 1))
				add_write(REG_ANTI_SHIFT, 3'($urandom_range(0, 1)));
			if ($urandom_range(0, 1))
				add_write(REG_MAX_ATTEMPTS, 3'($urandom_range(0, 7)));
			if ($urandom_range(0, 1))
				add_write(REG_FILTER, 3'($urandom_range(0, 3)));
			case ($urandom_range(0, 3))
				0: valid_pct = 95;
				1: valid_pct = 75;
				2: valid_pct = 50;
				default: valid_pct = 20;
			endcase
			back_to_back = ($urandom_range(0, 3) == 0);
			len = $urandom_range(40, 120);
			for (k = 0; k < len; k++) begin
				f = 16'($urandom);
				if ($urandom_range(0, 99) < valid_pct) begin
					f = f & ~ValidMask;
					if ($urandom_range(0, 3) != 0)
						f = f & ~FaultBit;
				end else begin
					do
						m = 16'($urandom) & ValidMask;
					while (m == '0);
					f = f | m;
				end
				add_frame(f);
				// occasional pause until every reading is back
				if (!back_to_back && $urandom_range(0, 49) == 0)
					add_settle();
			end
			total += len;
		end
		back_to_back = 1'b0;

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (frame_script.size() != 0 || in_valid || readings_seen != readings_due)
			@(posedge clk);
		repeat (TailWait) @(posedge clk);
		if (faults == 0 && pending_readings.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
